// ----- rtl/lldd_pkg.sv -----
package lldd_pkg;

   localparam int WINDOWS_DEF = 16;
   localparam int ACT_W       = 5;
   localparam int TICKET_W    = 16;
   localparam int SVC_W       = 16;
   localparam int WIN_W       = 5;
   localparam int LOAD_W      = 24;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_ADDR_W  = 3;

   localparam logic [ACT_W-1:0]    ACTIVE_RESET = 5'd16;
   localparam logic [TICKET_W-1:0] TICKET_RESET = 16'd764;
   localparam logic [LOAD_W-1:0]   LOAD_MAX     = 24'hFF_FFFF;

   localparam logic KIND_VISITOR = 1'b0;
   localparam logic KIND_REPORT  = 1'b1;

   localparam logic CSR_ACTIVE_WINDOWS = 1'b0;
   localparam logic CSR_FIRST_TICKET   = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_UPDATE,
      ST_VIS_WAIT,
      ST_RPT_RD,
      ST_RPT_LOAD,
      ST_RPT_WAIT
   } state_type;

   typedef enum logic {
      ALU_CMP,
      ALU_ADD
   } alu_op_type;

   typedef struct packed {
      logic wr_en;
      logic clear_all;
   } mem_ctl_type;

   typedef struct packed {
      logic              less;
      logic [LOAD_W-1:0] sum;
   } alu_res_type;

endpackage

// ----- rtl/lldd_alu.sv -----
module lldd_alu (
   input  lldd_pkg::alu_op_type          op,
   input  logic [lldd_pkg::LOAD_W-1:0]   a,
   input  logic [lldd_pkg::LOAD_W-1:0]   b,
   output lldd_pkg::alu_res_type         res
);
   import lldd_pkg::*;

   logic [LOAD_W:0] wide_sum;

   always_comb begin
      wide_sum = {1'b0, a} + {1'b0, b};
      res      = '0;
      case (op)
         ALU_CMP: begin
            res.less = (a < b);
         end
         ALU_ADD: begin
            res.sum = wide_sum[LOAD_W] ? LOAD_MAX : wide_sum[LOAD_W-1:0];
         end
         default: begin
            res = '0;
         end
      endcase
   end

endmodule

// ----- rtl/lldd_load_mem.sv -----
module lldd_load_mem #(
   parameter int WINDOWS = lldd_pkg::WINDOWS_DEF
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  lldd_pkg::mem_ctl_type                        ctl,
   input  logic [$clog2(WINDOWS > 1 ? WINDOWS : 2)-1:0] wr_addr,
   input  logic [lldd_pkg::LOAD_W-1:0]                  wr_data,
   input  logic [$clog2(WINDOWS > 1 ? WINDOWS : 2)-1:0] rd_addr,
   output logic [lldd_pkg::LOAD_W-1:0]                  rd_data
);
   import lldd_pkg::*;

   logic [LOAD_W-1:0]  mem_ff [WINDOWS];
   logic [WINDOWS-1:0] valid_ff;
   logic [LOAD_W-1:0]  rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || ctl.clear_all) begin
         valid_ff <= '0;
      end else if (ctl.wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= valid_ff[rd_addr] ? mem_ff[rd_addr] : '0;
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/least_loaded_window_dispatch_unit.sv -----
// Greedy least-loaded dispatcher. A visitor transfer (kind 0) gets the next ticket and goes to
// the active window with the smallest load, lowest window on ties; its service time is added
// to that load, saturating at 2^24-1, and one result with last set comes back. The loads sit
// in a memory with one write port and a registered read port, and one shared compare/add unit
// scans them one per cycle, then adds and writes back. A report transfer (kind 1) returns one
// line per active window in order, each in three steps (memory read, load, hand-off), then
// clears all loads and restarts tickets at first_ticket. The request side is stalled until
// the last result is taken, and the next request can be taken in the cycle after that.
// active_windows 0 counts as 1 and values above WINDOWS count as WINDOWS; a new first_ticket
// takes effect at the next report.
module least_loaded_window_dispatch_unit #(
   parameter int WINDOWS = lldd_pkg::WINDOWS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_kind,
   input  logic [lldd_pkg::SVC_W-1:0]           req_service_time,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_is_report,
   output logic [lldd_pkg::TICKET_W-1:0]        rsp_ticket,
   output logic [lldd_pkg::WIN_W-1:0]           rsp_window,
   output logic [lldd_pkg::LOAD_W-1:0]          rsp_window_load,
   output logic                                 rsp_last,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [lldd_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [lldd_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [lldd_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                 pready
);
   import lldd_pkg::*;

   localparam int IDX_W = $clog2(WINDOWS > 1 ? WINDOWS : 2);
   localparam int CNT_W = $clog2(WINDOWS + 1);

   state_type             state_ff, state_in;
   logic [CNT_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]      data_idx_ff, data_idx_in;
   logic [CNT_W-1:0]      n_ff, n_in;
   logic [CNT_W-1:0]      n_clamp;
   logic [SVC_W-1:0]      svc_ff, svc_in;
   logic [LOAD_W-1:0]     best_ff, best_in;
   logic [CNT_W-1:0]      best_idx_ff, best_idx_in;
   logic [TICKET_W-1:0]   next_ticket_ff, next_ticket_in;
   logic [ACT_W-1:0]      active_ff;
   logic [TICKET_W-1:0]   first_ff;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_is_report_ff, rsp_is_report_in;
   logic [TICKET_W-1:0]   rsp_ticket_ff, rsp_ticket_in;
   logic [WIN_W-1:0]      rsp_window_ff, rsp_window_in;
   logic [LOAD_W-1:0]     rsp_load_ff, rsp_load_in;
   logic                  rsp_last_ff, rsp_last_in;

   mem_ctl_type           mem_ctl;
   logic [IDX_W-1:0]      mem_rd_addr;
   logic [LOAD_W-1:0]     mem_rd_data;
   alu_op_type            alu_op;
   logic [LOAD_W-1:0]     alu_a, alu_b;
   alu_res_type           alu_res;
   logic                  csr_wr;

   lldd_load_mem #(
      .WINDOWS (WINDOWS)
   ) u_load_mem (
      .clock   (clock),
      .reset   (reset),
      .ctl     (mem_ctl),
      .wr_addr (best_idx_ff[IDX_W-1:0]),
      .wr_data (alu_res.sum),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   lldd_alu u_alu (
      .op  (alu_op),
      .a   (alu_a),
      .b   (alu_b),
      .res (alu_res)
   );

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= ACTIVE_RESET;
         first_ff  <= TICKET_RESET;
      end else if (csr_wr) begin
         unique case (paddr[2])
            CSR_ACTIVE_WINDOWS: active_ff <= pwdata[ACT_W-1:0];
            CSR_FIRST_TICKET:   first_ff  <= pwdata[TICKET_W-1:0];
            default:            active_ff <= active_ff;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         CSR_ACTIVE_WINDOWS: prdata = CSR_DATA_W'(active_ff);
         CSR_FIRST_TICKET:   prdata = CSR_DATA_W'(first_ff);
         default:            prdata = '0;
      endcase
   end

   always_comb begin
      if (active_ff == '0) begin
         n_clamp = CNT_W'(1);
      end else if (32'(active_ff) > WINDOWS) begin
         n_clamp = CNT_W'(WINDOWS);
      end else begin
         n_clamp = CNT_W'(active_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         next_ticket_ff <= TICKET_RESET;
      end else begin
         state_ff       <= state_in;
         rsp_valid_ff   <= rsp_valid_in;
         next_ticket_ff <= next_ticket_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_ptr_ff        <= rd_ptr_in;
      data_idx_ff      <= data_idx_in;
      n_ff             <= n_in;
      svc_ff           <= svc_in;
      best_ff          <= best_in;
      best_idx_ff      <= best_idx_in;
      rsp_is_report_ff <= rsp_is_report_in;
      rsp_ticket_ff    <= rsp_ticket_in;
      rsp_window_ff    <= rsp_window_in;
      rsp_load_ff      <= rsp_load_in;
      rsp_last_ff      <= rsp_last_in;
   end

   always_comb begin
      state_in         = state_ff;
      rd_ptr_in        = rd_ptr_ff;
      data_idx_in      = data_idx_ff;
      n_in             = n_ff;
      svc_in           = svc_ff;
      best_in          = best_ff;
      best_idx_in      = best_idx_ff;
      next_ticket_in   = next_ticket_ff;
      rsp_valid_in     = rsp_valid_ff;
      rsp_is_report_in = rsp_is_report_ff;
      rsp_ticket_in    = rsp_ticket_ff;
      rsp_window_in    = rsp_window_ff;
      rsp_load_in      = rsp_load_ff;
      rsp_last_in      = rsp_last_ff;
      mem_ctl          = '0;
      alu_op           = ALU_CMP;
      alu_a            = mem_rd_data;
      alu_b            = best_ff;
      mem_rd_addr      = (state_ff == ST_IDLE) ? '0 : rd_ptr_ff[IDX_W-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               n_in        = n_clamp;
               svc_in      = req_service_time;
               data_idx_in = '0;
               if (req_kind == KIND_REPORT) begin
                  rd_ptr_in = '0;
                  state_in  = ST_RPT_RD;
               end else begin
                  rd_ptr_in = CNT_W'(1);
                  state_in  = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (data_idx_ff == '0 || alu_res.less) begin
               best_in     = mem_rd_data;
               best_idx_in = data_idx_ff;
            end
            rd_ptr_in   = rd_ptr_ff + CNT_W'(1);
            data_idx_in = data_idx_ff + CNT_W'(1);
            if (data_idx_ff + CNT_W'(1) == n_ff) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            alu_op           = ALU_ADD;
            alu_a            = best_ff;
            alu_b            = LOAD_W'(svc_ff);
            mem_ctl.wr_en    = 1'b1;
            rsp_valid_in     = 1'b1;
            rsp_is_report_in = 1'b0;
            rsp_ticket_in    = next_ticket_ff;
            rsp_window_in    = WIN_W'(32'(best_idx_ff) + 32'd1);
            rsp_load_in      = alu_res.sum;
            rsp_last_in      = 1'b1;
            next_ticket_in   = next_ticket_ff + TICKET_W'(1);
            state_in         = ST_VIS_WAIT;
         end
         ST_VIS_WAIT: begin
            if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         ST_RPT_RD: begin
            state_in = ST_RPT_LOAD;
         end
         ST_RPT_LOAD: begin
            rsp_valid_in     = 1'b1;
            rsp_is_report_in = 1'b1;
            rsp_ticket_in    = '0;
            rsp_window_in    = WIN_W'(32'(rd_ptr_ff) + 32'd1);
            rsp_load_in      = mem_rd_data;
            rsp_last_in      = (rd_ptr_ff + CNT_W'(1) == n_ff);
            state_in         = ST_RPT_WAIT;
         end
         ST_RPT_WAIT: begin
            if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               if (rsp_last_ff) begin
                  mem_ctl.clear_all = 1'b1;
                  next_ticket_in    = first_ff;
                  state_in          = ST_IDLE;
               end else begin
                  rd_ptr_in = rd_ptr_ff + CNT_W'(1);
                  state_in  = ST_RPT_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_stall       = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_is_report   = rsp_is_report_ff;
   assign rsp_ticket      = rsp_ticket_ff;
   assign rsp_window      = rsp_window_ff;
   assign rsp_window_load = rsp_load_ff;
   assign rsp_last        = rsp_last_ff;

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == ST_VIS_WAIT || state_ff == ST_RPT_WAIT))
      else $error("result valid outside a wait state");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_is_report && rsp_last)
      |=> (next_ticket_ff == $past(first_ff)))
      else $error("ticket count not restarted after report");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_is_report && !rsp_last) |=> (state_ff == ST_RPT_RD))
      else $error("report did not advance to next window");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_is_report) |-> rsp_last)
      else $error("visitor result without last");
`endif

endmodule
